### src/bots_pkg.sv
`timescale 1ns / 1ps

package bots_pkg;

  // Table geometry
  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CFG_W      = 7;

  // Coordinate widths: edges are signed, sizes unsigned one bit narrower
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // Doubled centre 2*edge+size, difference of two centres, its magnitude
  localparam int CTR_W      = COORD_BITS + 2;
  localparam int DIFF_W     = CTR_W + 1;
  localparam int MAG_W      = DIFF_W - 1;
  // Sum of two sizes
  localparam int SUM_W      = COORD_BITS;

  // Stored entry: {h, w, cy, cx}
  localparam int ENTRY_W    = 2 * CTR_W + 2 * SIZE_BITS;

  // Stream payload widths
  localparam int IN_FIELDS_W = IDX_W + 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;

  // Item kinds carried in the input tuser bit
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;
    logic start;
    logic issue;
    logic flush;
    logic capture_hit;
    logic capture_miss;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             limit_zero;
    logic             last_issue;
    logic             pipe_busy;
    logic             found;
    logic [CFG_W-1:0] scan_limit;
  } ctrl_status_t;

endpackage

### src/bots_ram.sv
`timescale 1ns / 1ps

module bots_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/bots_datapath.sv
`timescale 1ns / 1ps

module bots_datapath import bots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          stat,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_hit
);

  // Doubled centre: 2*edge + size
  function automatic logic [CTR_W-1:0] centre(input logic [COORD_BITS-1:0] e,
                                              input logic [SIZE_BITS-1:0] s);
    return {e[COORD_BITS-1], e, 1'b0} + {3'b0, s};
  endfunction

  // Input fields
  logic [IDX_W-1:0]      in_index;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [SIZE_BITS-1:0]  in_w;
  logic [SIZE_BITS-1:0]  in_h;

  assign in_index = in_data[IDX_W-1:0];
  assign in_x     = in_data[IDX_W +: COORD_BITS];
  assign in_y     = in_data[IDX_W + COORD_BITS +: COORD_BITS];
  assign in_w     = in_data[IDX_W + 2 * COORD_BITS +: SIZE_BITS];
  assign in_h     = in_data[IDX_W + 2 * COORD_BITS + SIZE_BITS +: SIZE_BITS];

  logic [CTR_W-1:0] in_cx;
  logic [CTR_W-1:0] in_cy;

  assign in_cx = centre(in_x, in_w);
  assign in_cy = centre(in_y, in_h);

  // Scan limit register
  logic [CFG_W-1:0] active_entries;
  logic [CFG_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg_valid) begin
      active_entries <= cfg_data;
    end
  end

  // Saturate the scan count at the table depth
  assign limit = (active_entries > CFG_W'(ENTRIES)) ? CFG_W'(ENTRIES) : active_entries;

  // Read address counter
  logic [IDX_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr <= '0;
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end
  end

  // Rectangle table: entries stored as {h, w, cy, cx}
  logic [ENTRY_W-1:0] rd_data;

  bots_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (in_index),
    .wr_data ({in_h, in_w, in_cy, in_cx}),
    .rd_en   (cmd.issue),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  logic [CTR_W-1:0]     r_cx;
  logic [CTR_W-1:0]     r_cy;
  logic [SIZE_BITS-1:0] r_w;
  logic [SIZE_BITS-1:0] r_h;

  assign r_cx = rd_data[CTR_W-1:0];
  assign r_cy = rd_data[CTR_W +: CTR_W];
  assign r_w  = rd_data[2 * CTR_W +: SIZE_BITS];
  assign r_h  = rd_data[2 * CTR_W + SIZE_BITS +: SIZE_BITS];

  // Probe box, held for the whole scan
  logic [CTR_W-1:0]     p_cx;
  logic [CTR_W-1:0]     p_cy;
  logic [SIZE_BITS-1:0] p_w;
  logic [SIZE_BITS-1:0] p_h;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_cx <= in_cx;
      p_cy <= in_cy;
      p_w  <= in_w;
      p_h  <= in_h;
    end
  end

  // Pipeline valid bits
  logic v1;
  logic v2;
  logic v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue & ~cmd.flush;
      v2 <= v1 & ~cmd.flush;
      v3 <= v2 & ~cmd.flush;
    end
  end

  // Stage 2: centre differences and size sums
  logic [IDX_W-1:0]  idx1;
  logic [IDX_W-1:0]  idx2;
  logic [IDX_W-1:0]  idx3;
  logic [DIFF_W-1:0] dx2;
  logic [DIFF_W-1:0] dy2;
  logic [SUM_W-1:0]  sw;
  logic [SUM_W-1:0]  sh;

  always_ff @(posedge clk) begin
    idx1 <= addr;
    idx2 <= idx1;
    idx3 <= idx2;
    dx2  <= {p_cx[CTR_W-1], p_cx} - {r_cx[CTR_W-1], r_cx};
    dy2  <= {p_cy[CTR_W-1], p_cy} - {r_cy[CTR_W-1], r_cy};
    sw   <= {1'b0, p_w} + {1'b0, r_w};
    sh   <= {1'b0, p_h} + {1'b0, r_h};
  end

  // Stage 3: magnitudes, overlap test and overlap depths
  logic [DIFF_W-1:0] ndx;
  logic [DIFF_W-1:0] ndy;
  logic [MAG_W-1:0]  adx;
  logic [MAG_W-1:0]  ady;
  logic              ovx;
  logic              ovy;

  assign ndx = -dx2;
  assign ndy = -dy2;
  assign adx = dx2[DIFF_W-1] ? ndx[MAG_W-1:0] : dx2[MAG_W-1:0];
  assign ady = dy2[DIFF_W-1] ? ndy[MAG_W-1:0] : dy2[MAG_W-1:0];
  assign ovx = adx < {{(MAG_W - SUM_W){1'b0}}, sw};
  assign ovy = ady < {{(MAG_W - SUM_W){1'b0}}, sh};

  logic             ovl3;
  logic [SUM_W-1:0] ox3;
  logic [SUM_W-1:0] oy3;
  logic             dxpos3;
  logic             dypos3;

  always_ff @(posedge clk) begin
    ovl3   <= ovx & ovy;
    ox3    <= sw - adx[SUM_W-1:0];
    oy3    <= sh - ady[SUM_W-1:0];
    dxpos3 <= ~dx2[DIFF_W-1] & (dx2 != '0);
    dypos3 <= ~dy2[DIFF_W-1] & (dy2 != '0);
  end

  // Push along the shallower axis, vertical on a tie
  dir_t dir;

  always_comb begin
    if (ox3 < oy3) begin
      dir = dxpos3 ? DIR_LEFT : DIR_RIGHT;
    end else begin
      dir = dypos3 ? DIR_UP : DIR_DOWN;
    end
  end

  // Result holding register
  logic             res_hit;
  logic [IDX_W-1:0] res_idx;
  dir_t             res_dir;

  always_ff @(posedge clk) begin
    if (cmd.capture_hit) begin
      res_hit <= 1'b1;
      res_idx <= idx3;
      res_dir <= dir;
    end else if (cmd.capture_miss) begin
      res_hit <= 1'b0;
      res_idx <= '0;
      res_dir <= DIR_UP;
    end
  end

  // Output payload register
  logic             out_hit_r;
  logic [IDX_W-1:0] out_idx;
  dir_t             out_dir;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r <= res_hit;
      out_idx   <= res_idx;
      out_dir   <= res_dir;
    end
  end

  assign out_hit  = out_hit_r;
  assign out_data = {out_dir, out_idx};

  // Status to the controller
  assign stat.limit_zero = (limit == '0);
  assign stat.last_issue = ({1'b0, addr} == (limit - 1'b1));
  assign stat.pipe_busy  = v1 | v2 | v3;
  assign stat.found      = v3 & ovl3;
  assign stat.scan_limit = limit;

endmodule

### src/bots_ctrl.sv
`timescale 1ns / 1ps

module bots_ctrl import bots_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_kind,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ctrl_status_t stat,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = ~out_valid | out_ready;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == CMD_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            if (stat.limit_zero) begin
              cmd.capture_miss = 1'b1;
              state_next       = ST_REPORT;
            end else begin
              state_next = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (stat.found) begin
          cmd.capture_hit = 1'b1;
          cmd.flush       = 1'b1;
          state_next      = ST_REPORT;
        end else begin
          cmd.issue = 1'b1;
          if (stat.last_issue) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.found) begin
          cmd.capture_hit = 1'b1;
          cmd.flush       = 1'b1;
          state_next      = ST_REPORT;
        end else if (!stat.pipe_busy) begin
          cmd.capture_miss = 1'b1;
          state_next       = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/box_overlap_table_search.sv
`timescale 1ns / 1ps
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: entry_index..box_h; tuser: cmd
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: hit_index, direction; tuser: hit
//  cfg       in   cfg_valid / cfg_ready          cfg_data: active_entries
//
//  A query reads one table entry per cycle through the single read port of the table
//  RAM and reports the first overlapping slot, or a miss when no slot below the scan
//  limit overlaps; a zero limit goes straight to the report step. The next beat is
//  taken in the cycle after the result loads. rst is synchronous, active high; it clears
//  the scan limit and all control state, the table holds no reset value. A result
//  waiting on m_axis holds the next query at the report step until the beat is taken.

module box_overlap_table_search import bots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: entry_index[5:0], box_x[21:6], box_y[37:22], box_w[52:38], box_h[67:53]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[0]
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: hit_index[5:0], direction[7:6]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: hit[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  ctrl_cmd_t    cmd;
  ctrl_status_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  bots_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_hit   (m_axis_tuser)
  );

  bots_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

`ifndef NO_ASSERTIONS
  // An accepted query blocks the input until its result is reported
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
    else $error("input ready right after a query beat");

  // A miss reports zero index and zero direction
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result carries nonzero payload");

  // A reported hit lies inside the scanned range
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> ({1'b0, m_axis_tdata[IDX_W-1:0]} < stat.scan_limit))
    else $error("hit index beyond scan limit");

  // Reads stop once a hit has been found
  a_stop_on_hit: assert property (@(posedge clk) disable iff (rst)
    stat.found |-> !cmd.issue)
    else $error("table read issued after a hit");
`endif

endmodule

### bench/box_overlap_checker.sv
`timescale 1ns / 1ps

module box_overlap_checker import bots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]         w;
    logic [SIZE_BITS-1:0]         h;
  } rect_t;

  typedef struct {
    logic             hit;
    logic [IDX_W-1:0] index;
    dir_t             dir;
  } search_result_t;

  rect_t            rect_table [ENTRIES];
  logic [CFG_W-1:0] scan_count;
  search_result_t   expected_results [$];
  int               fail_count;

  initial fail_count = 0;

  // Scan the shadow table for the first strict overlap and pick the push axis
  function automatic search_result_t search_table(rect_t probe);
    search_result_t res;
    int limit, i, dx2, dy2, sw, sh, adx, ady, ox, oy;
    res.hit   = 1'b0;
    res.index = '0;
    res.dir   = DIR_UP;
    limit = (int'(scan_count) > ENTRIES) ? ENTRIES : int'(scan_count);
    for (i = 0; i < limit; i++) begin
      dx2 = (2 * int'(probe.x) + int'(probe.w)) -
            (2 * int'(rect_table[i].x) + int'(rect_table[i].w));
      dy2 = (2 * int'(probe.y) + int'(probe.h)) -
            (2 * int'(rect_table[i].y) + int'(rect_table[i].h));
      sw  = int'(probe.w) + int'(rect_table[i].w);
      sh  = int'(probe.h) + int'(rect_table[i].h);
      adx = (dx2 < 0) ? -dx2 : dx2;
      ady = (dy2 < 0) ? -dy2 : dy2;
      if (adx < sw && ady < sh) begin
        ox = sw - adx;
        oy = sh - ady;
        res.hit   = 1'b1;
        res.index = i[IDX_W-1:0];
        // Smaller overlap decides the axis; a tie goes vertical
        if (ox < oy)
          res.dir = (dx2 > 0) ? DIR_LEFT : DIR_RIGHT;
        else
          res.dir = (dy2 > 0) ? DIR_UP : DIR_DOWN;
        return res;
      end
    end
    return res;
  endfunction

  // Track config, writes and queries; compare each result beat in order
  always @(posedge clk) begin
    rect_t          item;
    search_result_t want;
    logic [IDX_W-1:0] got_index;
    logic [1:0]     got_dir;
    if (rst) begin
      scan_count = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_index = m_axis_tdata[IDX_W-1:0];
        got_dir   = m_axis_tdata[IDX_W +: 2];
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected: hit %0b index %0d dir %0d",
                   $time, m_axis_tuser, got_index, got_dir);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b",
                     $time, want.hit, m_axis_tuser);
            fail_count++;
          end
          if (got_index !== want.index) begin
            $display("%0t: hit_index mismatch: expected %0d, actual %0d",
                     $time, want.index, got_index);
            fail_count++;
          end
          if (got_dir !== want.dir) begin
            $display("%0t: direction mismatch: expected %0d, actual %0d",
                     $time, want.dir, got_dir);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        scan_count = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        item.x = s_axis_tdata[IDX_W +: COORD_BITS];
        item.y = s_axis_tdata[IDX_W + COORD_BITS +: COORD_BITS];
        item.w = s_axis_tdata[IDX_W + 2 * COORD_BITS +: SIZE_BITS];
        item.h = s_axis_tdata[IDX_W + 2 * COORD_BITS + SIZE_BITS +: SIZE_BITS];
        if (s_axis_tuser == CMD_WRITE)
          rect_table[s_axis_tdata[IDX_W-1:0]] = item;
        else
          expected_results.push_back(search_table(item));
      end
    end
    errors  <= fail_count;
    pending <= expected_results.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bots_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 105;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = CMD_WRITE;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  int   errors;
  int   pending;
  int   ready_hold = 0;
  logic stall_enable = 1'b1;
  int   n_writes = 0;
  int   n_queries = 0;
  int   n_limits = 0;

  box_overlap_table_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  box_overlap_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .errors        (errors),
    .pending       (pending)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(12, 60);
    return $urandom_range(0, 3);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stall_enable) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Drive one input beat, after a random gap when stalls are enabled, and hold it until taken
  task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] slot,
                           input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y,
                           input logic [SIZE_BITS-1:0] w,
                           input logic [SIZE_BITS-1:0] h);
    int gap;
    gap = stall_enable ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, h, w, y, x, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd == CMD_WRITE)
      n_writes++;
    else
      n_queries++;
  endtask

  // Make box content: mostly clustered at one of three scales, some full range
  task automatic make_box(output logic signed [COORD_BITS-1:0] x,
                          output logic signed [COORD_BITS-1:0] y,
                          output logic [SIZE_BITS-1:0] w,
                          output logic [SIZE_BITS-1:0] h);
    int span;
    if ($urandom_range(0, 9) == 0) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
      w = SIZE_BITS'($urandom);
      h = SIZE_BITS'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       span = 64;
        1:       span = 512;
        default: span = 4096;
      endcase
      x = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      y = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      w = SIZE_BITS'($urandom_range(0, span / 2));
      h = SIZE_BITS'($urandom_range(0, span / 2));
    end
  endtask

  // Drop valid and wait until every result is in and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scan(input logic [CFG_W-1:0] limit);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  initial begin
    int plan [PHASES];
    logic signed [COORD_BITS-1:0] bx, by;
    logic [SIZE_BITS-1:0] bw, bh;
    logic [IDX_W-1:0] slot;
    int limit;

    plan = '{64, 127, 1, 0, 65, -1, -1, 64};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty scan straight after reset
    send_beat(CMD_QUERY, 6'd63, 0, 0, 10, 10);

    // Seed the first slots: a plain box, the most negative corner, a point, an offset box
    send_beat(CMD_WRITE, 6'd0, 0, 0, 10, 10);
    send_beat(CMD_WRITE, 6'd1, -32768, -32768, 15'h7fff, 15'h7fff);
    send_beat(CMD_WRITE, 6'd2, 32767, 32767, 0, 0);
    send_beat(CMD_WRITE, 6'd3, 100, 100, 20, 20);
    set_scan(7'd4);

    // Each push direction, ties on both axes, touching edges, far slots, extremes
    send_beat(CMD_QUERY, 6'd0, 2, 0, 10, 10);
    send_beat(CMD_QUERY, 6'd0, -2, 0, 10, 10);
    send_beat(CMD_QUERY, 6'd0, 0, 2, 10, 10);
    send_beat(CMD_QUERY, 6'd0, 0, -2, 10, 10);
    send_beat(CMD_QUERY, 6'd0, 0, 0, 10, 10);
    send_beat(CMD_QUERY, 6'd0, 2, 2, 10, 10);
    send_beat(CMD_QUERY, 6'd0, 10, 0, 10, 10);
    send_beat(CMD_QUERY, 6'd0, -100, -100, 5, 5);
    send_beat(CMD_QUERY, 6'd0, 105, 105, 5, 5);
    send_beat(CMD_QUERY, 6'd0, -32768, -32768, 15'h7fff, 15'h7fff);
    send_beat(CMD_QUERY, 6'd0, 32767, 32767, 15'h7fff, 15'h7fff);
    send_beat(CMD_QUERY, 6'd0, 5, 5, 0, 0);

    // Fill the rest of the table so any scan limit stays on written slots
    for (int i = 4; i < ENTRIES; i++) begin
      make_box(bx, by, bw, bh);
      send_beat(CMD_WRITE, i[IDX_W-1:0], bx, by, bw, bh);
    end

    // Random mix of writes and searches under a series of scan limits
    for (int p = 0; p < PHASES; p++) begin
      limit = (plan[p] < 0) ? $urandom_range(2, 63) : plan[p];
      set_scan(limit[CFG_W-1:0]);
      stall_enable = (p % 3 != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        make_box(bx, by, bw, bh);
        slot = IDX_W'($urandom_range(0, ENTRIES - 1));
        send_beat(($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_QUERY, slot, bx, by, bw, bh);
      end
    end
    stall_enable = 1'b1;

    wait_idle();
    $display("Run covered %0d table writes and %0d searches over %0d scan limits,",
             n_writes, n_queries, n_limits);
    $display("from an empty scan through a full table and a saturated limit.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
